@@ rtl/core/http_chunked_decoder_assert.svh @@
// assertion macros for the chunked decoder
`ifndef HTTP_CHUNKED_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define HCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/hcd_pkg.sv @@
// shared types, constants and helpers for the chunked decoder
package hcd_pkg;

	localparam int SIZE_BITS_DEFAULT = 32;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	// end status codes
	typedef enum logic [1:0] {
		ST_STOPPED  = 2'd0,
		ST_BOUNDARY = 2'd1,
		ST_IN_SIZE  = 2'd2,
		ST_TRUNC    = 2'd3
	} end_status_t;

	// input item
	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} hcd_item_t;

	// result item
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_end;
		end_status_t end_status;
	} hcd_result_t;

	// hex digit decode: {is_hex, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

@@ rtl/core/hcd_if.sv @@
// stream channel interfaces for the chunked decoder

// input channel: body bytes and end marker
interface hcd_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

// output channel: payload bytes and end status
interface hcd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_end;
	logic [1:0] end_status;

	modport source (output valid, output out_byte, output is_end, output end_status,
		input ready);
	modport sink (input valid, input out_byte, input is_end, input end_status,
		output ready);
endinterface

@@ rtl/core/http_chunked_decoder.sv @@
// chunked transfer decoder top level
//
//   channel | dir | contents
//   in      | in  | func, data_byte (body byte or end marker)
//   out     | out | out_byte, is_end, end_status
//
// one item per cycle sustained while results are not stalled; an item passes
// the input register and then the result register around the parse logic.
// arst_n clears all parse state to the start of a size line.
// a stalled result holds the item in the input register, which then drops
// in.ready; items that give no result never wait on the output side.
`include "http_chunked_decoder_assert.svh"

module http_chunked_decoder
	import hcd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	hcd_in_if.sink     in,
	hcd_out_if.source  out
);

	hcd_item_t   in_item;
	hcd_item_t   item_s1;
	logic        valid_s1;
	logic        advance;
	logic        res_valid;
	hcd_result_t res;
	logic        load_ready;
	hcd_result_t out_res;

	assign in_item = '{func: in.func, data_byte: in.data_byte};

	// item leaves stage one when its result, if any, has room
	assign advance = valid_s1 && (!res_valid || load_ready);

	hcd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hcd_core #(
		.SIZE_BITS (SIZE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.step       (advance),
		.res_valid  (res_valid),
		.res        (res)
	);

	hcd_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && res_valid),
		.load_ready (load_ready),
		.load_res   (res),
		.out_valid  (out.valid),
		.out_ready  (out.ready),
		.out_res    (out_res)
	);

	assign out.out_byte   = out_res.out_byte;
	assign out.is_end     = out_res.is_end;
	assign out.end_status = out_res.end_status;

	// checks
	`HCD_ASSERT_NOW(a_end_byte_zero, out.valid && out.is_end, out.out_byte == 8'd0, "end result carries data")
	`HCD_ASSERT_NOW(a_payload_status, out.valid && !out.is_end, out.end_status == ST_STOPPED, "payload result carries status")
	`HCD_ASSERT_NEXT(a_stall_holds, valid_s1 && !advance, valid_s1 && $stable(item_s1), "stalled item lost")

endmodule

@@ rtl/core/hcd_in_reg.sv @@
// input register stage
module hcd_in_reg
	import hcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hcd_item_t in_item,
	input  logic      advance,
	output logic      valid_s1,
	output hcd_item_t item_s1
);

	// take a new item when empty or when the held one moves on
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ rtl/core/hcd_core.sv @@
// chunked parse state and per-byte result logic
module hcd_core
	import hcd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  hcd_item_t   item,
	input  logic        step,
	output logic        res_valid,
	output hcd_result_t res
);

	typedef enum logic [2:0] {
		PH_START, PH_LEAD, PH_NUM, PH_REST, PH_DATA, PH_TRAIL1, PH_TRAIL2, PH_STOPPED
	} phase_t;

	phase_t               phase_q, phase_n;
	logic [SIZE_BITS-1:0] count_q, count_n;
	logic                 neg_q, neg_n;
	logic [1:0]           prefix_q, prefix_n;
	logic                 digit_q, digit_n;
	logic                 cr_q, cr_n;

	logic [7:0]           c;
	logic [4:0]           hex;
	logic                 is_hex;
	logic                 sat;
	logic [SIZE_BITS-1:0] count_dig;
	logic [SIZE_BITS-1:0] count_dec;

	assign c         = item.data_byte;
	assign hex       = hex_decode(c);
	assign is_hex    = hex[4];
	// saturating shift-in of one hex digit
	assign sat       = |count_q[SIZE_BITS-1 -: 4];
	assign count_dig = sat ? '1 : {count_q[SIZE_BITS-5:0], hex[3:0]};
	assign count_dec = count_q - SIZE_BITS'(1);

	// next state and result
	always_comb begin
		phase_n   = phase_q;
		count_n   = count_q;
		neg_n     = neg_q;
		prefix_n  = prefix_q;
		digit_n   = digit_q;
		cr_n      = cr_q;
		res_valid = 1'b0;
		res       = '{out_byte: 8'd0, is_end: 1'b0, end_status: ST_STOPPED};

		if (item.func) begin
			// end marker: report where the stream stopped and start over
			res_valid = item_valid;
			res.is_end = 1'b1;
			unique case (phase_q)
				PH_STOPPED:                        res.end_status = ST_STOPPED;
				PH_START, PH_TRAIL1, PH_TRAIL2:    res.end_status = ST_BOUNDARY;
				PH_DATA:                           res.end_status = ST_TRUNC;
				default:                           res.end_status = ST_IN_SIZE;
			endcase
			phase_n  = PH_START;
			count_n  = '0;
			neg_n    = 1'b0;
			prefix_n = 2'd0;
			digit_n  = 1'b0;
			cr_n     = 1'b0;
		end else begin
			unique case (phase_q)
				PH_DATA: begin
					res_valid    = item_valid;
					res.out_byte = c;
					count_n      = count_dec;
					if (count_dec == '0) begin
						phase_n = PH_TRAIL1;
					end
				end
				PH_TRAIL1: begin
					phase_n = PH_TRAIL2;
				end
				PH_TRAIL2: begin
					phase_n  = PH_START;
					count_n  = '0;
					neg_n    = 1'b0;
					prefix_n = 2'd0;
					digit_n  = 1'b0;
					cr_n     = 1'b0;
				end
				PH_STOPPED: begin
					phase_n = PH_STOPPED;
				end
				default: begin
					if (cr_q && c == CH_LF) begin
						// end of size line: judge the size
						if (!digit_q || count_q == '0 || neg_q) begin
							phase_n = PH_STOPPED;
						end else begin
							phase_n = PH_DATA;
						end
						neg_n    = 1'b0;
						prefix_n = 2'd0;
						digit_n  = 1'b0;
						cr_n     = 1'b0;
					end else begin
						cr_n = (c == CH_CR);
						if (phase_q == PH_START || phase_q == PH_LEAD) begin
							if (c == CH_SP || c == CH_TAB) begin
								phase_n = PH_LEAD;
							end else if (c == CH_PLUS || c == CH_MINUS) begin
								neg_n   = (c == CH_MINUS);
								phase_n = PH_NUM;
							end else if (is_hex) begin
								prefix_n = (c == CH_ZERO) ? 2'd1 : 2'd2;
								count_n  = count_dig;
								digit_n  = 1'b1;
								phase_n  = PH_NUM;
							end else begin
								phase_n = PH_REST;
							end
						end else if (phase_q == PH_NUM) begin
							if (prefix_q == 2'd1 && (c == CH_X_LO || c == CH_X_UP)) begin
								prefix_n = 2'd2;
							end else if (is_hex) begin
								if (prefix_q == 2'd0) begin
									prefix_n = (c == CH_ZERO) ? 2'd1 : 2'd2;
								end else begin
									prefix_n = 2'd2;
								end
								count_n = count_dig;
								digit_n = 1'b1;
							end else begin
								phase_n = PH_REST;
							end
						end
					end
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			count_q  <= '0;
			neg_q    <= 1'b0;
			prefix_q <= 2'd0;
			digit_q  <= 1'b0;
			cr_q     <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			count_q  <= count_n;
			neg_q    <= neg_n;
			prefix_q <= prefix_n;
			digit_q  <= digit_n;
			cr_q     <= cr_n;
		end
	end

endmodule

@@ rtl/core/hcd_out_reg.sv @@
// result register stage
module hcd_out_reg
	import hcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	output logic        load_ready,
	input  hcd_result_t load_res,
	output logic        out_valid,
	input  logic        out_ready,
	output hcd_result_t out_res
);

	logic        valid_q;
	hcd_result_t res_q;

	// free when empty or when the held result transfers this cycle
	assign load_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_res    = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load_ready && load) begin
			res_q <= load_res;
		end
	end

endmodule
